// ===== src/plc_priority_and_backoff_access_core_macros.svh =====
// Assertion macros shared by the channel-access core.
`ifndef PLC_PRIORITY_AND_BACKOFF_ACCESS_CORE_MACROS_SVH
`define PLC_PRIORITY_AND_BACKOFF_ACCESS_CORE_MACROS_SVH

// The condition holds at every rising clock edge outside reset.
`define PBA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PBA_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/plc_pba_pkg.sv =====
// Shared types, codes and table functions of the channel-access core.
package plc_pba_pkg;

    // Access phases.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SLOT1   = 3'd1;
    localparam logic [2:0] PH_SLOT2   = 3'd2;
    localparam logic [2:0] PH_BACKOFF = 3'd3;
    localparam logic [2:0] PH_TX      = 3'd4;

    // Operation codes of an input item.
    localparam logic [2:0] OP_REQUEST = 3'd0;
    localparam logic [2:0] OP_SLOT1   = 3'd1;
    localparam logic [2:0] OP_SLOT2   = 3'd2;
    localparam logic [2:0] OP_BACKOFF = 3'd3;
    localparam logic [2:0] OP_TX_DONE = 3'd4;

    // Event codes of a result item.
    localparam logic [2:0] EV_IGNORED  = 3'd0;
    localparam logic [2:0] EV_RESOLVE  = 3'd1;
    localparam logic [2:0] EV_LOST     = 3'd2;
    localparam logic [2:0] EV_BO_START = 3'd3;
    localparam logic [2:0] EV_TRANSMIT = 3'd4;
    localparam logic [2:0] EV_REJECTED = 3'd5;
    localparam logic [2:0] EV_BO_CONT  = 3'd6;
    localparam logic [2:0] EV_TX_END   = 3'd7;

    // Contention window selects.
    localparam logic [1:0] WIN_7  = 2'd0;
    localparam logic [1:0] WIN_15 = 2'd1;
    localparam logic [1:0] WIN_31 = 2'd2;
    localparam logic [1:0] WIN_63 = 2'd3;

    localparam logic [1:0] STAGE_MAX    = 2'd3;
    localparam logic [5:0] WINDOW_RESET = 6'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] priority_req;
        logic       heard;
        logic       busy_req;
        logic [5:0] random;
    } t_item;

    typedef struct packed {
        logic [2:0] event_res;
        logic       send_priority_signal;
        logic [1:0] backoff_stage;
        logic [3:0] deferral_count;
        logic [5:0] backoff_count;
        logic [5:0] contention_window;
    } t_result;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] held_priority;
        logic       first_heard;
        logic [1:0] stage;
        logic [3:0] defer_left;
        logic [5:0] slots_left;
        logic [5:0] window;
    } t_state;

    function automatic logic [3:0] defer_of(input logic [1:0] stage);
        logic [3:0] d;
        unique case (stage)
            2'd0: d = 4'd0;
            2'd1: d = 4'd1;
            2'd2: d = 4'd3;
            default: d = 4'd15;
        endcase
        return d;
    endfunction

    // High priorities (CA2, CA3) use the narrower windows in the upper stages.
    function automatic logic [1:0] win_sel_of(input logic [1:0] stage,
                                              input logic high_prio);
        logic [1:0] s;
        unique case (stage)
            2'd0: s = WIN_7;
            2'd1: s = WIN_15;
            2'd2: s = high_prio ? WIN_15 : WIN_31;
            default: s = high_prio ? WIN_31 : WIN_63;
        endcase
        return s;
    endfunction

    function automatic logic [5:0] win_value(input logic [1:0] sel);
        logic [5:0] w;
        unique case (sel)
            WIN_7:  w = 6'd7;
            WIN_15: w = 6'd15;
            WIN_31: w = 6'd31;
            default: w = 6'd63;
        endcase
        return w;
    endfunction

    // Remainder by 2^k - 1: fold the high bits onto the low bits, then one
    // compare and subtract.
    function automatic logic [5:0] mod_window(input logic [5:0] rnd,
                                              input logic [1:0] sel);
        logic [3:0] f7a;
        logic [3:0] f7b;
        logic [4:0] f15;
        logic [5:0] f31;
        logic [5:0] r;
        f7a = {1'b0, rnd[2:0]} + {1'b0, rnd[5:3]};
        f7b = {1'b0, f7a[2:0]} + {3'b000, f7a[3]};
        f15 = {1'b0, rnd[3:0]} + {3'b000, rnd[5:4]};
        f31 = {1'b0, rnd[4:0]} + {5'b00000, rnd[5]};
        unique case (sel)
            WIN_7:  r = (f7b >= 4'd7) ? {2'b00, 4'(f7b - 4'd7)} : {2'b00, f7b};
            WIN_15: r = (f15 >= 5'd15) ? {1'b0, 5'(f15 - 5'd15)} : {1'b0, f15};
            WIN_31: r = (f31 >= 6'd31) ? 6'(f31 - 6'd31) : f31;
            default: r = (rnd == 6'd63) ? 6'd0 : rnd;
        endcase
        return r;
    endfunction

endpackage

// ===== src/plc_pba_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
interface plc_pba_in_if import plc_pba_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [1:0] priority_req;
    logic       heard;
    logic       busy_req;
    logic [5:0] random;

    modport source (output valid, op, priority_req, heard, busy_req, random,
                    input ready);
    modport sink   (input valid, op, priority_req, heard, busy_req, random,
                    output ready);
endinterface

interface plc_pba_out_if import plc_pba_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic       send_priority_signal;
    logic [1:0] backoff_stage;
    logic [3:0] deferral_count;
    logic [5:0] backoff_count;
    logic [5:0] contention_window;

    modport source (output valid, event_res, send_priority_signal, backoff_stage,
                    deferral_count, backoff_count, contention_window,
                    input ready);
    modport sink   (input valid, event_res, send_priority_signal, backoff_stage,
                    deferral_count, backoff_count, contention_window,
                    output ready);
endinterface

// ===== src/plc_priority_and_backoff_access_core.sv =====
// Top level of the power-line priority resolution and backoff access core.
//
// Usage:
// The core takes access events on the i_in channel (frame request, end of the
// first or second priority slot, backoff slot tick, transmit done) and returns
// exactly one result per event on the o_out channel. Each result carries the
// event code, whether to assert the priority signal in the next slot, and the
// backoff stage, deferral counter, backoff counter and contention window as
// they stand after the event.
// A result is registered in the output entry when that entry is free or
// being taken, else in the skid entry. Throughput is one transfer per cycle
// while the skid entry is empty; the whole update of the access state is one
// pass of logic between the state registers and the result register.
// A two-entry result buffer parts the channels. While the receiver stalls,
// one more input transfer is taken into the skid entry; after that i_in.ready
// drops until the receiver takes a result.
// Reset (synchronous, active low) returns the core to idle with all counters
// at zero, the window at seven and both result entries empty.
`include "plc_priority_and_backoff_access_core_macros.svh"

module plc_priority_and_backoff_access_core import plc_pba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    plc_pba_in_if.sink        i_in,
    plc_pba_out_if.source     o_out
);

    t_state  r_state;
    t_state  n_state;
    t_item   item;
    t_result step_result;
    t_result buf_result;
    logic    in_ready;
    logic    in_fire;

    // Gather the input payload into one item.
    assign item.op           = i_in.op;
    assign item.priority_req = i_in.priority_req;
    assign item.heard        = i_in.heard;
    assign item.busy_req     = i_in.busy_req;
    assign item.random       = i_in.random;

    assign i_in.ready = in_ready;
    assign in_fire    = i_in.valid && in_ready;

    // Event decode and counter update for the current access state.
    plc_pba_step u_step (
        .i_state  (r_state),
        .i_item   (item),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // The access state advances on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_IDLE;
            r_state.held_priority <= 2'd0;
            r_state.first_heard   <= 1'b0;
            r_state.stage         <= 2'd0;
            r_state.defer_left    <= 4'd0;
            r_state.slots_left    <= 6'd0;
            r_state.window        <= WINDOW_RESET;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Results wait here for the receiver.
    plc_pba_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (in_ready),
        .i_data  (step_result),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (buf_result)
    );

    assign o_out.event_res            = buf_result.event_res;
    assign o_out.send_priority_signal = buf_result.send_priority_signal;
    assign o_out.backoff_stage        = buf_result.backoff_stage;
    assign o_out.deferral_count       = buf_result.deferral_count;
    assign o_out.backoff_count        = buf_result.backoff_count;
    assign o_out.contention_window    = buf_result.contention_window;

    // A transmit event always leaves the core in the transmitting phase.
    `PBA_ASSERT_NEXT(a_tx_enters_phase, in_fire && step_result.event_res == EV_TRANSMIT, r_state.phase == PH_TX, "transmit event did not enter transmitting phase")

    // While transmitting, the stage and both counters have been cleared.
    `PBA_ASSERT_IMPLIES(a_tx_counters_clear, r_state.phase == PH_TX, r_state.stage == 2'd0 && r_state.defer_left == 4'd0 && r_state.slots_left == 6'd0, "counters not clear while transmitting")

    // During backoff the slot counter stays below the contention window.
    `PBA_ASSERT_IMPLIES(a_slots_in_window, r_state.phase == PH_BACKOFF, r_state.slots_left < r_state.window, "backoff counter outside the window")

    // The priority signal is only requested with a resolution event.
    `PBA_ASSERT_IMPLIES(a_signal_on_resolve, o_out.valid && o_out.send_priority_signal, o_out.event_res == EV_RESOLVE, "priority signal outside resolution")

endmodule

// ===== src/plc_pba_step.sv =====
// Next-state and result logic for one access event.
module plc_pba_step import plc_pba_pkg::*; (
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    t_state     n_st;
    logic [2:0] ev;
    logic       sig;
    logic       lost;
    logic [1:0] draw_stage;
    logic [1:0] draw_sel;
    logic [3:0] dec_defer;
    logic [5:0] dec_slots;
    logic [1:0] busy_stage;

    always_comb begin
        dec_slots  = (i_state.slots_left != 6'd0) ? 6'(i_state.slots_left - 6'd1)
                                                  : 6'd0;
        dec_defer  = (i_state.defer_left != 4'd0) ? 4'(i_state.defer_left - 4'd1)
                                                  : 4'd0;
        busy_stage = (i_state.stage < STAGE_MAX) ? 2'(i_state.stage + 2'd1)
                                                 : STAGE_MAX;
        // A win at the second slot draws at stage zero; a busy slot that
        // runs out of deferral draws at the raised stage.
        draw_stage = (i_state.phase == PH_BACKOFF) ? busy_stage : 2'd0;
        draw_sel   = win_sel_of(draw_stage, i_state.held_priority[1]);

        unique case (i_state.held_priority)
            2'd0: lost = i_state.first_heard | i_item.heard;
            2'd1: lost = i_state.first_heard;
            2'd2: lost = i_state.first_heard & i_item.heard;
            default: lost = 1'b0;
        endcase

        n_st = i_state;
        ev   = EV_IGNORED;
        sig  = 1'b0;

        unique case (i_item.op)
            OP_REQUEST: begin
                if (i_state.phase == PH_IDLE) begin
                    n_st.held_priority = i_item.priority_req;
                    n_st.first_heard   = 1'b0;
                    n_st.phase         = PH_SLOT1;
                    sig                = i_item.priority_req[1];
                    ev                 = EV_RESOLVE;
                end else begin
                    ev = EV_REJECTED;
                end
            end
            OP_SLOT1: begin
                if (i_state.phase == PH_SLOT1) begin
                    n_st.first_heard = i_item.heard;
                    n_st.phase       = PH_SLOT2;
                    sig              = i_state.held_priority[0];
                    ev               = EV_RESOLVE;
                end
            end
            OP_SLOT2: begin
                if (i_state.phase == PH_SLOT2) begin
                    if (lost) begin
                        n_st.stage      = 2'd0;
                        n_st.defer_left = 4'd0;
                        n_st.slots_left = 6'd0;
                        n_st.phase      = PH_IDLE;
                        ev              = EV_LOST;
                    end else begin
                        n_st.stage      = 2'd0;
                        n_st.defer_left = defer_of(2'd0);
                        n_st.window     = win_value(draw_sel);
                        n_st.slots_left = mod_window(i_item.random, draw_sel);
                        n_st.phase      = PH_BACKOFF;
                        ev              = EV_BO_START;
                    end
                end
            end
            OP_BACKOFF: begin
                if (i_state.phase == PH_BACKOFF) begin
                    if (i_item.busy_req) begin
                        n_st.slots_left = dec_slots;
                        n_st.defer_left = dec_defer;
                        if (dec_defer == 4'd0) begin
                            n_st.stage      = busy_stage;
                            n_st.defer_left = defer_of(busy_stage);
                            n_st.window     = win_value(draw_sel);
                            n_st.slots_left = mod_window(i_item.random, draw_sel);
                        end
                        ev = EV_BO_CONT;
                    end else if (dec_slots == 6'd0) begin
                        n_st.stage      = 2'd0;
                        n_st.defer_left = 4'd0;
                        n_st.slots_left = 6'd0;
                        n_st.phase      = PH_TX;
                        ev              = EV_TRANSMIT;
                    end else begin
                        n_st.slots_left = dec_slots;
                        ev              = EV_BO_CONT;
                    end
                end
            end
            OP_TX_DONE: begin
                if (i_state.phase == PH_TX) begin
                    n_st.phase = PH_IDLE;
                    ev         = EV_TX_END;
                end
            end
            default: begin
                ev = EV_IGNORED;
            end
        endcase

        o_state                       = n_st;
        o_result.event_res            = ev;
        o_result.send_priority_signal = sig;
        o_result.backoff_stage        = n_st.stage;
        o_result.deferral_count       = n_st.defer_left;
        o_result.backoff_count        = n_st.slots_left;
        o_result.contention_window    = n_st.window;
    end

endmodule

// ===== src/plc_pba_outbuf.sv =====
// Two-entry result buffer (output register plus skid register).
module plc_pba_outbuf import plc_pba_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    in_take;
    logic    out_take;

    assign o_ready  = !r_skid_valid;
    assign in_take  = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_take) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_take) begin
            if (!r_out_valid || out_take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the power-line priority resolution and backoff access core.
module tb;
    import plc_pba_pkg::*;

    // Channel-access priorities of a frame request.
    localparam logic [1:0] CA0 = 2'd0;
    localparam logic [1:0] CA1 = 2'd1;
    localparam logic [1:0] CA2 = 2'd2;
    localparam logic [1:0] CA3 = 2'd3;

    // Mirror of the access engine. It follows every accepted transfer on the
    // input channel, keeps the results that the core owes in arrival order and
    // compares each returned result against the oldest one still owed.
    class access_mirror;
        logic [2:0]  phase;
        logic [1:0]  prio;
        logic        first_heard;
        logic [1:0]  stage;
        logic [3:0]  defer_left;
        logic [5:0]  slots_left;
        logic [5:0]  window;
        t_result     owed_q[$];
        int unsigned mismatches;
        int unsigned ev_seen[8];
        int unsigned saturated_draws;

        function new();
            phase       = PH_IDLE;
            prio        = CA0;
            first_heard = 1'b0;
            stage       = 2'd0;
            defer_left  = 4'd0;
            slots_left  = 6'd0;
            window      = WINDOW_RESET;
            mismatches  = 0;
            saturated_draws = 0;
            foreach (ev_seen[k]) ev_seen[k] = 0;
        endfunction

        // Load deferral and window for the current stage and draw the slot counter.
        function void redraw(logic [5:0] rnd);
            case (stage)
                2'd0: begin
                    defer_left = 4'd0;
                    window     = 6'd7;
                end
                2'd1: begin
                    defer_left = 4'd1;
                    window     = 6'd15;
                end
                2'd2: begin
                    defer_left = 4'd3;
                    window     = (prio >= CA2) ? 6'd15 : 6'd31;
                end
                default: begin
                    defer_left = 4'd15;
                    window     = (prio >= CA2) ? 6'd31 : 6'd63;
                end
            endcase
            slots_left = 6'(int'(rnd) % int'(window));
        endfunction

        function void clear_counters();
            stage      = 2'd0;
            defer_left = 4'd0;
            slots_left = 6'd0;
        endfunction

        function string show(t_result r);
            return $sformatf("ev=%0d sig=%0d stage=%0d defer=%0d slots=%0d win=%0d",
                             r.event_res, r.send_priority_signal, r.backoff_stage,
                             r.deferral_count, r.backoff_count, r.contention_window);
        endfunction

        function void report(string what, t_result want, t_result got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch (%s): expected %s, got %s",
                         $realtime, what, show(want), show(got));
        endfunction

        // Advance the mirror by one accepted input and queue the result it owes.
        function logic [2:0] note_event(t_item it);
            t_result r;
            logic    lost;
            r    = '0;
            lost = 1'b0;
            r.event_res = EV_IGNORED;
            case (it.op)
                OP_REQUEST: begin
                    if (phase == PH_IDLE) begin
                        prio        = it.priority_req;
                        first_heard = 1'b0;
                        phase       = PH_SLOT1;
                        r.send_priority_signal = (it.priority_req == CA2) ||
                                                 (it.priority_req == CA3);
                        r.event_res = EV_RESOLVE;
                    end else begin
                        r.event_res = EV_REJECTED;
                    end
                end
                OP_SLOT1: begin
                    if (phase == PH_SLOT1) begin
                        first_heard = it.heard;
                        phase       = PH_SLOT2;
                        r.send_priority_signal = (prio == CA1) || (prio == CA3);
                        r.event_res = EV_RESOLVE;
                    end
                end
                OP_SLOT2: begin
                    if (phase == PH_SLOT2) begin
                        case (prio)
                            CA0: lost = first_heard || it.heard;
                            CA1: lost = first_heard;
                            CA2: lost = first_heard && it.heard;
                            default: lost = 1'b0;
                        endcase
                        if (lost) begin
                            clear_counters();
                            phase       = PH_IDLE;
                            r.event_res = EV_LOST;
                        end else begin
                            stage = 2'd0;
                            redraw(it.random);
                            phase       = PH_BACKOFF;
                            r.event_res = EV_BO_START;
                        end
                    end
                end
                OP_BACKOFF: begin
                    if (phase == PH_BACKOFF) begin
                        if (slots_left != 6'd0) slots_left--;
                        if (it.busy_req) begin
                            if (defer_left != 4'd0) defer_left--;
                            if (defer_left == 4'd0) begin
                                if (stage < STAGE_MAX) stage++;
                                else saturated_draws++;
                                redraw(it.random);
                            end
                            r.event_res = EV_BO_CONT;
                        end else if (slots_left == 6'd0) begin
                            clear_counters();
                            phase       = PH_TX;
                            r.event_res = EV_TRANSMIT;
                        end else begin
                            r.event_res = EV_BO_CONT;
                        end
                    end
                end
                OP_TX_DONE: begin
                    if (phase == PH_TX) begin
                        phase       = PH_IDLE;
                        r.event_res = EV_TX_END;
                    end
                end
                default: ;
            endcase
            r.backoff_stage     = stage;
            r.deferral_count    = defer_left;
            r.backoff_count     = slots_left;
            r.contention_window = window;
            owed_q = {owed_q, r};
            ev_seen[r.event_res]++;
            return r.event_res;
        endfunction

        function void check_result(t_result got);
            t_result want;
            string   diffs;
            if (owed_q.size() == 0) begin
                report("no result owed", '0, got);
                return;
            end
            want  = owed_q[0];
            owed_q.delete(0);
            diffs = "";
            if (got.event_res !== want.event_res) diffs = {diffs, " event"};
            if (got.send_priority_signal !== want.send_priority_signal)
                diffs = {diffs, " signal"};
            if (got.backoff_stage !== want.backoff_stage) diffs = {diffs, " stage"};
            if (got.deferral_count !== want.deferral_count) diffs = {diffs, " deferral"};
            if (got.backoff_count !== want.backoff_count) diffs = {diffs, " backoff"};
            if (got.contention_window !== want.contention_window)
                diffs = {diffs, " window"};
            if (diffs != "") report({"field", diffs}, want, got);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    plc_pba_in_if  in_ch ();
    plc_pba_out_if out_ch ();

    plc_priority_and_backoff_access_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    access_mirror book = new();

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int unsigned src_idle_pct = 0;
    int unsigned dst_idle_pct = 0;
    // Accepted input transfers, ignored operations included.
    int unsigned total_items = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the core stops moving transfers.
    initial begin
        #5_000_000;
        $display("run timed out with %0d results still owed", book.owed_q.size());
        $display("tb: failure");
        $finish;
    end

    // The receiver picks its ready for the next edge on every falling edge.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Every result transfer is checked at the rising edge that completes it.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.event_res            = out_ch.event_res;
            got.send_priority_signal = out_ch.send_priority_signal;
            got.backoff_stage        = out_ch.backoff_stage;
            got.deferral_count       = out_ch.deferral_count;
            got.backoff_count        = out_ch.backoff_count;
            got.contention_window    = out_ch.contention_window;
            book.check_result(got);
        end
    end

    function automatic t_item mk(logic [2:0] op, logic [1:0] pr, logic hd, logic bz,
                                 logic [5:0] rnd);
        t_item it;
        it.op           = op;
        it.priority_req = pr;
        it.heard        = hd;
        it.busy_req     = bz;
        it.random       = rnd;
        return it;
    endfunction

    // Offer one input transfer. Called and returning at a falling edge; the
    // sender may first hold valid low for a random number of cycles, with the
    // payload scrambled so that stale fields are never relied upon.
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid        = 1'b0;
            in_ch.op           = 3'($urandom_range(7));
            in_ch.priority_req = 2'($urandom_range(3));
            in_ch.heard        = 1'($urandom_range(1));
            in_ch.busy_req     = 1'($urandom_range(1));
            in_ch.random       = 6'($urandom_range(63));
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.op           = it.op;
        in_ch.priority_req = it.priority_req;
        in_ch.heard        = it.heard;
        in_ch.busy_req     = it.busy_req;
        in_ch.random       = it.random;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        total_items++;
        void'(book.note_event(it));
        @(negedge i_clk);
    endtask

    // Hold the sender until the core has returned everything it owes.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (book.owed_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_item       directed[$];
        t_item       it;
        int unsigned target;
        int unsigned busy_pct;
        int unsigned round;
        bit          failed;

        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.op           = OP_REQUEST;
        in_ch.priority_req = CA0;
        in_ch.heard        = 1'b0;
        in_ch.busy_req     = 1'b0;
        in_ch.random       = 6'd0;
        busy_pct           = 40;

        // Directed walk: stray operations while idle, every loss rule, a win for
        // CA2 and for CA3, stage climbs under a busy medium, requests rejected
        // mid-access, a zero backoff draw that transmits at once, and the
        // extremes of the random draw.
        directed = {directed, mk(OP_TX_DONE, CA0, 1'b0, 1'b0, 6'd0)};
        directed = {directed, mk(3'd7, CA3, 1'b1, 1'b1, 6'd63)};
        directed = {directed, mk(3'd5, CA1, 1'b0, 1'b1, 6'd21)};
        directed = {directed, mk(OP_SLOT2, CA0, 1'b1, 1'b1, 6'd0)};
        directed = {directed, mk(OP_REQUEST, CA0, 1'b0, 1'b0, 6'd0)};
        directed = {directed, mk(OP_REQUEST, CA3, 1'b1, 1'b1, 6'd63)};
        directed = {directed, mk(OP_SLOT1, CA2, 1'b0, 1'b0, 6'd0)};
        directed = {directed, mk(OP_SLOT2, CA0, 1'b1, 1'b0, 6'd5)};
        directed = {directed, mk(OP_REQUEST, CA1, 1'b0, 1'b0, 6'd0)};
        directed = {directed, mk(OP_SLOT1, CA0, 1'b1, 1'b0, 6'd0)};
        directed = {directed, mk(OP_SLOT2, CA0, 1'b0, 1'b0, 6'd9)};
        directed = {directed, mk(OP_REQUEST, CA2, 1'b0, 1'b0, 6'd0)};
        directed = {directed, mk(OP_SLOT1, CA0, 1'b1, 1'b0, 6'd0)};
        directed = {directed, mk(OP_SLOT2, CA0, 1'b1, 1'b0, 6'd40)};
        directed = {directed, mk(OP_REQUEST, CA2, 1'b0, 1'b0, 6'd0)};
        directed = {directed, mk(OP_SLOT1, CA0, 1'b1, 1'b0, 6'd0)};
        directed = {directed, mk(OP_SLOT2, CA0, 1'b0, 1'b0, 6'd62)};
        directed = {directed, mk(OP_BACKOFF, CA0, 1'b0, 1'b1, 6'd63)};
        directed = {directed, mk(OP_BACKOFF, CA0, 1'b0, 1'b1, 6'd0)};
        directed = {directed, mk(OP_REQUEST, CA1, 1'b0, 1'b0, 6'd7)};
        directed = {directed, mk(OP_BACKOFF, CA0, 1'b0, 1'b0, 6'd0)};
        directed = {directed, mk(OP_BACKOFF, CA0, 1'b0, 1'b0, 6'd0)};
        directed = {directed, mk(OP_TX_DONE, CA0, 1'b0, 1'b0, 6'd0)};
        directed = {directed, mk(OP_REQUEST, CA3, 1'b0, 1'b0, 6'd0)};
        directed = {directed, mk(OP_SLOT1, CA0, 1'b1, 1'b0, 6'd0)};
        directed = {directed, mk(OP_SLOT2, CA0, 1'b1, 1'b0, 6'd63)};
        directed = {directed, mk(OP_BACKOFF, CA0, 1'b0, 1'b0, 6'd0)};
        directed = {directed, mk(OP_TX_DONE, CA0, 1'b0, 1'b0, 6'd0)};

        // Synchronous reset is held low from the start and released at a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle_pct = 6;
        dst_idle_pct = 72;
        foreach (directed[k]) send_item(directed[k]);
        drain();

        // Random traffic in three rounds: a slow receiver, then a slow sender,
        // then full rate on both sides. Most transfers follow a well-formed
        // access (request, two priority slots, backoff until transmit, transmit
        // done) with random content; the rest are arbitrary operations.
        for (round = 0; round < 3; round++) begin
            case (round)
                0: begin
                    src_idle_pct = 6;
                    dst_idle_pct = 72;
                end
                1: begin
                    src_idle_pct = 72;
                    dst_idle_pct = 6;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            target = total_items + 307;
            while (total_items < target) begin
                it = mk(3'($urandom_range(7)), 2'($urandom_range(3)),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        6'($urandom_range(63)));
                if ($urandom_range(99) < 85) begin
                    case (book.phase)
                        PH_IDLE: begin
                            it.op = OP_REQUEST;
                            // Each frame gets its own busy-medium density so that
                            // some accesses climb to the saturated stage.
                            case ($urandom_range(2))
                                0: busy_pct = 10;
                                1: busy_pct = 45;
                                default: busy_pct = 90;
                            endcase
                        end
                        PH_SLOT1: begin
                            it.op    = OP_SLOT1;
                            it.heard = ($urandom_range(99) < 35);
                        end
                        PH_SLOT2: begin
                            it.op    = OP_SLOT2;
                            it.heard = ($urandom_range(99) < 35);
                        end
                        PH_BACKOFF: begin
                            it.op       = OP_BACKOFF;
                            it.busy_req = ($urandom_range(99) < busy_pct);
                        end
                        default: it.op = OP_TX_DONE;
                    endcase
                end
                send_item(it);
            end
            drain();
        end

        // A few more cycles for anything the core might still put out.
        repeat (4) @(negedge i_clk);

        failed = (book.mismatches != 0) || (book.owed_q.size() != 0);
        if (book.owed_q.size() != 0)
            $display("%0d results never arrived", book.owed_q.size());
        $display("covered %0d input transfers: %0d resolution steps, %0d losses, %0d rejects,",
                 total_items, book.ev_seen[EV_RESOLVE], book.ev_seen[EV_LOST],
                 book.ev_seen[EV_REJECTED]);
        $display("  %0d backoffs, %0d transmits, %0d saturated redraws, %0d ignored; %0d mismatches",
                 book.ev_seen[EV_BO_START], book.ev_seen[EV_TRANSMIT],
                 book.saturated_draws, book.ev_seen[EV_IGNORED], book.mismatches);
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/plc_pba_pkg.sv
src/plc_pba_if.sv
src/plc_pba_step.sv
src/plc_pba_outbuf.sv
src/plc_priority_and_backoff_access_core.sv
verif/tb.sv
